/* design/ccpd_pkg.sv */
// Package: shared types, codes, reset values and the CRC byte step for the deframer.
`timescale 1ns / 1ps
package ccpd_pkg;

  // Default largest payload length accepted
  localparam int unsigned PAYLOAD_MAX_DEF = 256;

  // Configuration register reset values
  localparam logic [7:0]  START_BYTE_RST      = 8'hA5;
  localparam logic [15:0] CRC_SEED_RST        = 16'hFFFF;
  localparam logic [15:0] HUNT_TIMEOUT_RST    = 16'd5000;
  localparam logic [15:0] FIELD_TIMEOUT_RST   = 16'd1000;
  localparam logic [15:0] PAYLOAD_TIMEOUT_RST = 16'd2000;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] TICK_SAT = 16'hFFFF;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_BYTE      = 3'd0,
    CFG_CRC_SEED        = 3'd1,
    CFG_HUNT_TIMEOUT    = 3'd2,
    CFG_FIELD_TIMEOUT   = 3'd3,
    CFG_PAYLOAD_TIMEOUT = 3'd4
  } cfg_idx_t;

  // Input beat operation
  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  // Result kind
  typedef enum logic {
    KIND_BYTE   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  // End-of-packet status
  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_CRC_BAD  = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_TIMEOUT  = 2'd3
  } status_t;

  // Deframer phase
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_SEQ     = 3'd1,
    PH_LEN0    = 3'd2,
    PH_LEN1    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CRC0    = 3'd5,
    PH_CRC1    = 3'd6
  } phase_t;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [7:0]  byte_index;
    logic [7:0]  sequence_res;
    logic [15:0] length;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [15:0] crc_seed;
    logic [15:0] hunt_timeout;
    logic [15:0] field_timeout;
    logic [15:0] payload_timeout;
  } cfg_t;

  // One byte of CRC-16-CCITT, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* design/ccpd_cfg_regs.sv */
// Configuration register file of the deframer.
`timescale 1ns / 1ps
module ccpd_cfg_regs
  import ccpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  assign cfg = cfg_r;

  // Write the addressed register; ignore unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte      <= START_BYTE_RST;
      cfg_r.crc_seed        <= CRC_SEED_RST;
      cfg_r.hunt_timeout    <= HUNT_TIMEOUT_RST;
      cfg_r.field_timeout   <= FIELD_TIMEOUT_RST;
      cfg_r.payload_timeout <= PAYLOAD_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_BYTE:      cfg_r.start_byte      <= cfg_wdata[7:0];
        CFG_CRC_SEED:        cfg_r.crc_seed        <= cfg_wdata;
        CFG_HUNT_TIMEOUT:    cfg_r.hunt_timeout    <= cfg_wdata;
        CFG_FIELD_TIMEOUT:   cfg_r.field_timeout   <= cfg_wdata;
        CFG_PAYLOAD_TIMEOUT: cfg_r.payload_timeout <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

/* design/ccpd_frame_fsm.sv */
// Framing state machine: phase, counters and CRC, one beat per cycle while go is high.
`timescale 1ns / 1ps
module ccpd_frame_fsm
  import ccpd_pkg::*;
#(
  parameter int unsigned PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      go,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output logic      res_valid,
  output out_item_t res
);

  localparam logic [15:0] LEN_MAX = 16'(PAYLOAD_MAX);

  phase_t      phase_r, phase_nxt;
  logic [15:0] byte_count_r, byte_count_nxt;
  logic [15:0] length_r, length_nxt;
  logic [7:0]  sequence_r, sequence_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [15:0] tick_r, tick_nxt;

  logic [15:0] tick_inc;
  logic [15:0] limit;
  logic [15:0] crc_step;
  logic [15:0] len_full;
  logic [16:0] count_inc;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      byte_count_r <= '0;
      length_r     <= '0;
      sequence_r   <= '0;
      crc_r        <= CRC_SEED_RST;
      crc_lo_r     <= '0;
      tick_r       <= '0;
    end else if (go) begin
      phase_r      <= phase_nxt;
      byte_count_r <= byte_count_nxt;
      length_r     <= length_nxt;
      sequence_r   <= sequence_nxt;
      crc_r        <= crc_nxt;
      crc_lo_r     <= crc_lo_nxt;
      tick_r       <= tick_nxt;
    end
  end

  assign tick_inc  = (tick_r == TICK_SAT) ? tick_r : tick_r + 16'd1;
  assign crc_step  = crc_byte(crc_r, item.rx_byte);
  assign len_full  = {item.rx_byte, length_r[7:0]};
  assign count_inc = {1'b0, byte_count_r} + 17'd1;

  // Pick the timeout limit of the current phase
  always_comb begin
    if (phase_r == PH_HUNT) begin
      limit = cfg.hunt_timeout;
    end else if (phase_r == PH_PAYLOAD) begin
      limit = cfg.payload_timeout;
    end else begin
      limit = cfg.field_timeout;
    end
  end

  // Next state and result for one beat
  always_comb begin
    phase_nxt      = phase_r;
    byte_count_nxt = byte_count_r;
    length_nxt     = length_r;
    sequence_nxt   = sequence_r;
    crc_nxt        = crc_r;
    crc_lo_nxt     = crc_lo_r;
    tick_nxt       = tick_r;
    res_valid      = 1'b0;
    res.kind         = KIND_STATUS;
    res.payload_byte = '0;
    res.byte_index   = '0;
    res.sequence_res = sequence_r;
    res.length       = length_r;
    res.status       = ST_GOOD;

    if (item.op == OP_TICK) begin
      // Count the tick and time out at the phase limit
      tick_nxt = tick_inc;
      if (tick_inc >= limit) begin
        res_valid  = 1'b1;
        res.status = ST_TIMEOUT;
        phase_nxt  = PH_HUNT;
        tick_nxt   = '0;
        if (phase_r == PH_HUNT) begin
          res.sequence_res = '0;
          res.length       = '0;
        end
      end
    end else begin
      unique case (phase_r)
        PH_HUNT: begin
          tick_nxt = '0;
          if (item.rx_byte == cfg.start_byte) begin
            sequence_nxt   = '0;
            length_nxt     = '0;
            byte_count_nxt = '0;
            crc_lo_nxt     = '0;
            crc_nxt        = cfg.crc_seed;
            phase_nxt      = PH_SEQ;
          end
        end
        PH_SEQ: begin
          sequence_nxt = item.rx_byte;
          crc_nxt      = crc_step;
          phase_nxt    = PH_LEN0;
          tick_nxt     = '0;
        end
        PH_LEN0: begin
          length_nxt = {8'h00, item.rx_byte};
          crc_nxt    = crc_step;
          phase_nxt  = PH_LEN1;
        end
        PH_LEN1: begin
          length_nxt = len_full;
          crc_nxt    = crc_step;
          if (len_full > LEN_MAX) begin
            // Drop an oversize packet
            res_valid  = 1'b1;
            res.length = len_full;
            res.status = ST_TOO_LONG;
            phase_nxt  = PH_HUNT;
            tick_nxt   = '0;
          end else begin
            byte_count_nxt = '0;
            phase_nxt      = (len_full == 16'd0) ? PH_CRC0 : PH_PAYLOAD;
            tick_nxt       = '0;
          end
        end
        PH_PAYLOAD: begin
          crc_nxt          = crc_step;
          res_valid        = 1'b1;
          res.kind         = KIND_BYTE;
          res.payload_byte = item.rx_byte;
          res.byte_index   = byte_count_r[7:0];
          byte_count_nxt   = count_inc[15:0];
          if (count_inc >= {1'b0, length_r}) begin
            phase_nxt = PH_CRC0;
            tick_nxt  = '0;
          end
        end
        PH_CRC0: begin
          crc_lo_nxt = item.rx_byte;
          phase_nxt  = PH_CRC1;
        end
        PH_CRC1: begin
          res_valid  = 1'b1;
          res.status = ({item.rx_byte, crc_lo_r} == crc_r) ? ST_GOOD : ST_CRC_BAD;
          phase_nxt  = PH_HUNT;
          tick_nxt   = '0;
        end
        default: begin
          phase_nxt = PH_HUNT;
          tick_nxt  = '0;
        end
      endcase
    end
  end

endmodule

/* design/crc_checked_packet_deframer.sv */
// Top level of the CRC-checked packet deframer: input stage, state machine, result stage.
`timescale 1ns / 1ps
// Usage:
//   The input channel carries one beat per received byte or per millisecond
//   tick (in_data.op). The block hunts for the start byte, reads sequence,
//   length, payload and CRC, and emits each payload byte on the result
//   channel as it arrives, then one status beat per packet (good, CRC
//   mismatch, length too large, timeout). The consumer drops the payload
//   bytes of a packet whose status is bad.
//   Throughput: one input beat per cycle while no stall holds a result. A beat is held
//   in the input register; the state machine processes it from there into the result
//   register. The single state-update pass per cycle sets this rate.
//   Stall: while out_stall holds a result, the state machine waits and the
//   input register fills; in_stall then rises until the result is taken.
//   Reset (rst_n low, synchronous) empties both stages, returns to hunting and loads the
//   configuration registers with their default values. Configuration is written through
//   cfg_we/cfg_index/cfg_wdata by the user while idle; the block does not enforce it.
module crc_checked_packet_deframer
  import ccpd_pkg::*;
#(
  parameter int unsigned PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg;
  logic      in_v_r;
  in_item_t  in_item_r;
  logic      out_v_r;
  out_item_t out_item_r;
  logic      out_free;
  logic      proc_go;
  logic      res_valid;
  out_item_t res;

  ccpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ccpd_frame_fsm #(
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (proc_go),
    .item      (in_item_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_free  = !out_v_r || !out_stall;
  assign proc_go   = in_v_r && out_free;
  assign in_stall  = in_v_r && !proc_go;
  assign out_valid = out_v_r;
  assign out_data  = out_item_r;

  // Input stage: take a beat when empty or draining
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_v_r <= 1'b1;
    end else if (proc_go) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
  end

  // Result stage: load on processing, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (proc_go) begin
      out_v_r <= res_valid;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && res_valid) begin
      out_item_r <= res;
    end
  end

endmodule

/* tb/tb_crc_checked_packet_deframer.sv */
// Testbench for the CRC-checked packet deframer: directed and random frames against a predictor.
`timescale 1ns / 1ps
module tb_crc_checked_packet_deframer;
  import ccpd_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  crc_checked_packet_deframer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Predictor copy of the configuration
  logic [7:0]  cfg_start;
  logic [15:0] cfg_seed;
  logic [15:0] cfg_hunt_to;
  logic [15:0] cfg_field_to;
  logic [15:0] cfg_payload_to;

  // Predictor copy of the deframer state
  phase_t      m_phase;
  logic [15:0] m_count;
  logic [15:0] m_len;
  logic [7:0]  m_seq;
  logic [15:0] m_crc;
  logic [15:0] m_crc_rx;
  logic [15:0] m_ticks;

  out_item_t frame_results_q[$];
  int        beats_counted = 0;
  int        error_count = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Bit-serial CRC-16-CCITT, MSB first
  function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] r;
    r = crc;
    for (int k = 7; k >= 0; k--) begin
      if (r[15] ^ b[k]) begin
        r = {r[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic void reset_deframer_model();
    cfg_start      = START_BYTE_RST;
    cfg_seed       = CRC_SEED_RST;
    cfg_hunt_to    = HUNT_TIMEOUT_RST;
    cfg_field_to   = FIELD_TIMEOUT_RST;
    cfg_payload_to = PAYLOAD_TIMEOUT_RST;
    m_phase  = PH_HUNT;
    m_count  = '0;
    m_len    = '0;
    m_seq    = '0;
    m_crc    = CRC_SEED_RST;
    m_crc_rx = '0;
    m_ticks  = '0;
  endfunction

  // Queue an end-of-packet status and go back to hunting
  function automatic void end_packet(status_t st, logic [7:0] sq, logic [15:0] ln);
    out_item_t r;
    r = '0;
    r.kind         = KIND_STATUS;
    r.sequence_res = sq;
    r.length       = ln;
    r.status       = st;
    frame_results_q.push_back(r);
    m_phase = PH_HUNT;
    m_ticks = '0;
  endfunction

  // Advance the predictor by one accepted input beat
  function automatic void deframe_beat(in_item_t it);
    out_item_t   r;
    logic [15:0] limit;
    logic [7:0]  b;
    b = it.rx_byte;
    if (!(it.op == OP_BYTE && m_phase == PH_HUNT && b != cfg_start)) begin
      beats_counted++;
    end
    if (it.op == OP_TICK) begin
      if (m_ticks != TICK_SAT) m_ticks++;
      case (m_phase)
        PH_HUNT:    limit = cfg_hunt_to;
        PH_PAYLOAD: limit = cfg_payload_to;
        default:    limit = cfg_field_to;
      endcase
      if (m_ticks >= limit) begin
        if (m_phase == PH_HUNT) end_packet(ST_TIMEOUT, 8'h00, 16'h0000);
        else end_packet(ST_TIMEOUT, m_seq, m_len);
      end
      return;
    end
    case (m_phase)
      PH_HUNT: begin
        m_ticks = '0;
        if (b == cfg_start) begin
          m_seq    = '0;
          m_len    = '0;
          m_count  = '0;
          m_crc_rx = '0;
          m_crc    = cfg_seed;
          m_phase  = PH_SEQ;
        end
      end
      PH_SEQ: begin
        m_seq   = b;
        m_crc   = crc16_update(m_crc, b);
        m_phase = PH_LEN0;
        m_ticks = '0;
      end
      PH_LEN0: begin
        m_len   = {8'h00, b};
        m_crc   = crc16_update(m_crc, b);
        m_phase = PH_LEN1;
      end
      PH_LEN1: begin
        m_len = {b, m_len[7:0]};
        m_crc = crc16_update(m_crc, b);
        if (m_len > PAYLOAD_MAX_DEF) begin
          end_packet(ST_TOO_LONG, m_seq, m_len);
        end else begin
          m_count = '0;
          m_phase = (m_len == 16'd0) ? PH_CRC0 : PH_PAYLOAD;
          m_ticks = '0;
        end
      end
      PH_PAYLOAD: begin
        m_crc = crc16_update(m_crc, b);
        r = '0;
        r.kind         = KIND_BYTE;
        r.payload_byte = b;
        r.byte_index   = m_count[7:0];
        r.sequence_res = m_seq;
        r.length       = m_len;
        r.status       = ST_GOOD;
        frame_results_q.push_back(r);
        m_count++;
        if (m_count >= m_len) begin
          m_phase = PH_CRC0;
          m_ticks = '0;
        end
      end
      PH_CRC0: begin
        m_crc_rx = {8'h00, b};
        m_phase  = PH_CRC1;
      end
      PH_CRC1: begin
        m_crc_rx = {b, m_crc_rx[7:0]};
        end_packet((m_crc_rx == m_crc) ? ST_GOOD : ST_CRC_BAD, m_seq, m_len);
      end
      default: begin
        m_phase = PH_HUNT;
        m_ticks = '0;
      end
    endcase
  endfunction

  // Random receiver backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_results_q.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("unexpected result beat: kind=%0d byte=%02h idx=%0d seq=%02h len=%0d st=%0d",
                   out_data.kind, out_data.payload_byte, out_data.byte_index,
                   out_data.sequence_res, out_data.length, out_data.status);
        end
      end else begin
        e = frame_results_q.pop_front();
        if (out_data.kind !== e.kind || out_data.payload_byte !== e.payload_byte ||
            out_data.byte_index !== e.byte_index || out_data.sequence_res !== e.sequence_res ||
            out_data.length !== e.length || out_data.status !== e.status) begin
          error_count++;
          if (error_count <= 10) begin
            $display("mismatch: exp kind=%0d byte=%02h idx=%0d seq=%02h len=%0d st=%0d",
                     e.kind, e.payload_byte, e.byte_index, e.sequence_res, e.length,
                     e.status);
            $display("          got kind=%0d byte=%02h idx=%0d seq=%02h len=%0d st=%0d",
                     out_data.kind, out_data.payload_byte, out_data.byte_index,
                     out_data.sequence_res, out_data.length, out_data.status);
          end
        end
      end
    end
  end

  // Send one input beat; return at the edge that accepts it
  task automatic send_beat(op_t op, logic [7:0] b);
    in_item_t it;
    it.op      = op;
    it.rx_byte = b;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    deframe_beat(it);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_beat(OP_TICK, 8'($urandom));
  endtask

  task automatic send_noise(int n);
    repeat (n) send_beat(OP_BYTE, 8'($urandom));
  endtask

  // Send start byte, header and, for an accepted length, payload and CRC; fill < 0 means random payload
  task automatic send_frame(logic [7:0] sq, logic [15:0] len_field, logic [15:0] crc_xor,
                            int tick_pct, int fill);
    logic [7:0]  body[$];
    logic [15:0] crc;
    int          npay;
    body = {};
    body.push_back(sq);
    body.push_back(len_field[7:0]);
    body.push_back(len_field[15:8]);
    npay = (len_field > PAYLOAD_MAX_DEF) ? 0 : int'(len_field);
    for (int i = 0; i < npay; i++) begin
      body.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    end
    crc = cfg_seed;
    foreach (body[i]) crc = crc16_update(crc, body[i]);
    if (npay == int'(len_field)) begin
      crc = crc ^ crc_xor;
      body.push_back(crc[7:0]);
      body.push_back(crc[15:8]);
    end
    send_beat(OP_BYTE, cfg_start);
    foreach (body[i]) begin
      if ($urandom_range(99) < tick_pct) send_beat(OP_TICK, 8'($urandom));
      send_beat(OP_BYTE, body[i]);
    end
  endtask

  // Drop valid, drain every prediction, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write one register, then hold the port idle before returning
  task automatic write_cfg(cfg_idx_t idx, logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_START_BYTE:      cfg_start      = v[7:0];
      CFG_CRC_SEED:        cfg_seed       = v;
      CFG_HUNT_TIMEOUT:    cfg_hunt_to    = v;
      CFG_FIELD_TIMEOUT:   cfg_field_to   = v;
      CFG_PAYLOAD_TIMEOUT: cfg_payload_to = v;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_pressure(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 56; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 56; end
      default: begin send_idle_pct = 31; stall_pct = 31; end
    endcase
  endtask

  // Reset configuration: short good frames, empty payload, bad CRC
  task automatic test_default_frames();
    send_frame(8'h01, 16'd1, 16'h0000, 0, -1);
    send_frame(8'h02, 16'd0, 16'h0000, 0, -1);
    send_frame(8'h03, 16'd2, 16'h8001, 0, -1);
  endtask

  // Extreme start bytes, seeds, sequence numbers and length fields
  task automatic test_field_extremes();
    wait_idle();
    write_cfg(CFG_START_BYTE, 16'h00FF);
    write_cfg(CFG_CRC_SEED, 16'h0000);
    send_frame(8'hFF, 16'd2, 16'h0000, 0, 8'hFF);
    send_frame(8'h00, 16'd257, 16'h0000, 0, -1);
    send_frame(8'h7F, 16'hFFFF, 16'h0000, 0, -1);
    wait_idle();
    write_cfg(CFG_START_BYTE, 16'h0000);
    write_cfg(CFG_CRC_SEED, 16'hFFFF);
    send_frame(8'h80, 16'd2, 16'h0000, 0, 8'h00);
  endtask

  // Largest accepted payload
  task automatic test_max_length();
    wait_idle();
    write_cfg(CFG_CRC_SEED, 16'($urandom));
    send_frame(8'($urandom), 16'(PAYLOAD_MAX_DEF), 16'h0000, 0, -1);
  endtask

  // Timeout in the hunt, sequence, second length, payload and second CRC phases, then zero timeout registers
  task automatic test_timeouts();
    wait_idle();
    write_cfg(CFG_START_BYTE, 16'h00A5);
    write_cfg(CFG_HUNT_TIMEOUT, 16'd2);
    write_cfg(CFG_FIELD_TIMEOUT, 16'd2);
    write_cfg(CFG_PAYLOAD_TIMEOUT, 16'd3);
    send_ticks(2);
    send_beat(OP_BYTE, 8'hA5);
    send_ticks(2);
    send_beat(OP_BYTE, 8'hA5);
    send_beat(OP_BYTE, 8'h5A);
    send_beat(OP_BYTE, 8'h02);
    send_ticks(2);
    send_beat(OP_BYTE, 8'hA5);
    send_beat(OP_BYTE, 8'h5B);
    send_beat(OP_BYTE, 8'h02);
    send_beat(OP_BYTE, 8'h00);
    send_beat(OP_BYTE, 8'h33);
    send_ticks(3);
    send_beat(OP_BYTE, 8'hA5);
    send_beat(OP_BYTE, 8'h5C);
    send_beat(OP_BYTE, 8'h00);
    send_beat(OP_BYTE, 8'h00);
    send_beat(OP_BYTE, 8'h12);
    send_ticks(2);
    wait_idle();
    write_cfg(CFG_FIELD_TIMEOUT, 16'd0);
    write_cfg(CFG_HUNT_TIMEOUT, 16'd0);
    write_cfg(CFG_PAYLOAD_TIMEOUT, 16'd0);
    send_ticks(1);
    send_beat(OP_BYTE, 8'hA5);
    send_ticks(1);
    send_frame(8'h44, 16'd1, 16'h0000, 100, -1);
  endtask

  // Random traffic over several configurations and pressure modes
  task automatic test_random_traffic(int total);
    int target;
    int r;
    int ln;
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      set_pressure(ph % 4);
      case (ph)
        0: begin
          write_cfg(CFG_START_BYTE, 16'h00FF);
          write_cfg(CFG_CRC_SEED, 16'h0000);
          write_cfg(CFG_HUNT_TIMEOUT, 16'hFFFF);
          write_cfg(CFG_FIELD_TIMEOUT, 16'hFFFF);
          write_cfg(CFG_PAYLOAD_TIMEOUT, 16'hFFFF);
        end
        1: begin
          write_cfg(CFG_START_BYTE, 16'h0000);
          write_cfg(CFG_CRC_SEED, 16'hFFFF);
          write_cfg(CFG_HUNT_TIMEOUT, 16'd1);
          write_cfg(CFG_FIELD_TIMEOUT, 16'd1);
          write_cfg(CFG_PAYLOAD_TIMEOUT, 16'd1);
        end
        default: begin
          write_cfg(CFG_START_BYTE, 16'($urandom_range(255)));
          write_cfg(CFG_CRC_SEED, 16'($urandom));
          write_cfg(CFG_HUNT_TIMEOUT, 16'($urandom_range(3, 40)));
          write_cfg(CFG_FIELD_TIMEOUT, 16'($urandom_range(3, 30)));
          write_cfg(CFG_PAYLOAD_TIMEOUT, 16'($urandom_range(10, 200)));
        end
      endcase
      target = beats_counted + total / 8;
      while (beats_counted < target) begin
        r  = $urandom_range(99);
        ln = ($urandom_range(99) < 3) ? $urandom_range(9, PAYLOAD_MAX_DEF)
                                      : $urandom_range(0, 8);
        if (r < 60) begin
          send_frame(8'($urandom), 16'(ln), 16'h0000, 5, -1);
        end else if (r < 72) begin
          send_frame(8'($urandom), 16'(ln), 16'($urandom_range(1, 65535)), 5, -1);
        end else if (r < 78) begin
          send_frame(8'($urandom), 16'($urandom_range(PAYLOAD_MAX_DEF + 1, 65535)),
                     16'h0000, 5, -1);
        end else if (r < 88) begin
          // Truncate a frame, then send ticks that may time it out
          send_beat(OP_BYTE, cfg_start);
          send_noise($urandom_range(1, 4));
          send_ticks($urandom_range(1, 40));
        end else begin
          send_noise($urandom_range(1, 5));
          send_ticks($urandom_range(0, 3));
        end
      end
    end
  endtask

  initial begin
    reset_deframer_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_default_frames();
    test_field_extremes();
    test_max_length();
    test_timeouts();
    test_random_traffic(300);
    wait_idle();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
design/ccpd_pkg.sv
design/ccpd_cfg_regs.sv
design/ccpd_frame_fsm.sv
design/crc_checked_packet_deframer.sv
tb/tb_crc_checked_packet_deframer.sv
